FILE: sv/qed_pkg.sv
// Package: shared types, widths and constants of the quadrature encoder decoder.
`timescale 1ns / 1ps

package qed_pkg;

    localparam int ENCODER_COUNT = 16;
    localparam int TIME_SAMPLES  = 8;

    localparam int ENC_IDX_W   = 4;
    localparam int TIME_W      = 32;
    localparam int DIR_W       = 2;
    localparam int LEVEL_W     = 3;
    localparam int LIMIT_W     = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int PHASE_W     = 2;

    localparam int ENC_W     = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;
    localparam int HEAD_W    = $clog2(TIME_SAMPLES);
    localparam int RAM_DEPTH = ENCODER_COUNT * TIME_SAMPLES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef logic [PHASE_W-1:0]       phase_t;
    typedef logic signed [DIR_W-1:0]  dir_t;
    typedef logic [LEVEL_W-1:0]       level_t;
    typedef logic [LIMIT_W-1:0]       limit_t;
    typedef logic [TIME_W-1:0]        time_t;
    typedef logic [ENC_IDX_W-1:0]     enc_t;
    typedef logic [HEAD_W-1:0]        head_t;
    typedef logic [RAM_AW-1:0]        ram_addr_t;

    localparam dir_t DIR_NONE = 2'sb00;
    localparam dir_t DIR_POS  = 2'sb01;
    localparam dir_t DIR_NEG  = 2'sb11;

    localparam level_t LEVEL_FASTEST = 3'd4;
    localparam level_t LEVEL_FAST    = 3'd3;
    localparam level_t LEVEL_MEDIUM  = 3'd2;
    localparam level_t LEVEL_SLOW    = 3'd1;
    localparam level_t LEVEL_STILL   = 3'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FASTEST_LIMIT = 8'd0,
        CFG_FAST_LIMIT    = 8'd1,
        CFG_MEDIUM_LIMIT  = 8'd2,
        CFG_SLOW_LIMIT    = 8'd3
    } cfg_index_t;

    localparam limit_t FASTEST_LIMIT_RESET = 16'd5;
    localparam limit_t FAST_LIMIT_RESET    = 16'd15;
    localparam limit_t MEDIUM_LIMIT_RESET  = 16'd28;
    localparam limit_t SLOW_LIMIT_RESET    = 16'd120;

    // last three raw steps, h0 newest
    typedef struct packed {
        dir_t h2;
        dir_t h1;
        dir_t h0;
    } hist_t;

    // step handed from the tracking stage to the speed stage
    typedef struct packed {
        enc_t  enc;
        dir_t  dir;
        time_t now;
        logic  back_valid;
    } step_t;

    // step-time RAM access
    typedef struct packed {
        logic      we;
        ram_addr_t waddr;
        time_t     wdata;
        logic      re;
        ram_addr_t raddr;
    } ram_req_t;

endpackage

FILE: sv/qed_sample_if.sv
// Interface: encoder sample channel.
`timescale 1ns / 1ps

interface qed_sample_if import qed_pkg::*; ();
    logic  valid;
    logic  ready;
    enc_t  encoder_index;
    logic  phase_a;
    logic  phase_b;
    time_t now_ms;

    modport source (output valid, output encoder_index, output phase_a, output phase_b,
                    output now_ms, input ready);
    modport sink (input valid, input encoder_index, input phase_a, input phase_b,
                  input now_ms, output ready);
endinterface

FILE: sv/qed_event_if.sv
// Interface: encoder movement event channel.
`timescale 1ns / 1ps

interface qed_event_if import qed_pkg::*; ();
    logic   valid;
    logic   ready;
    enc_t   which_encoder;
    dir_t   direction;
    level_t speed_level;

    modport source (output valid, output which_encoder, output direction,
                    output speed_level, input ready);
    modport sink (input valid, input which_encoder, input direction,
                  input speed_level, output ready);
endinterface

FILE: sv/qed_cfg_if.sv
// Interface: configuration register write channel.
`timescale 1ns / 1ps

interface qed_cfg_if import qed_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    limit_t                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/qed_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module qed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/qed_track.sv
// Tracking stage: input register, per-encoder phase, direction filter and ring head.
`timescale 1ns / 1ps

module qed_track import qed_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    qed_sample_if.sink   samples,
    input  logic         step_ready,
    output logic         step_valid,
    output step_t        step,
    output ram_req_t     ram
);

    logic   s1_valid_reg;
    enc_t   s1_enc_reg;
    phase_t s1_phase_reg;
    time_t  s1_now_reg;

    phase_t phase_reg [ENCODER_COUNT];
    hist_t  hist_reg  [ENCODER_COUNT];
    head_t  head_reg  [ENCODER_COUNT];
    logic [RAM_DEPTH-1:0] ring_valid_reg;

    logic [ENC_W-1:0] enc_idx;
    logic   in_range;
    phase_t prev;
    phase_t plus1;
    phase_t minus1;
    dir_t   raw;
    dir_t   dir;
    hist_t  hist;
    hist_t  hist_next;
    head_t  head;
    head_t  head_next;
    head_t  back;
    logic   is_step;
    logic   s1_done;

    function automatic ram_addr_t slot_addr(input logic [ENC_W-1:0] e, input head_t slot);
        return RAM_AW'(e) * RAM_AW'(TIME_SAMPLES) + RAM_AW'(slot);
    endfunction

    always_comb
    begin
        enc_idx  = ENC_W'(s1_enc_reg);
        in_range = int'(s1_enc_reg) < ENCODER_COUNT;
        prev     = phase_reg[enc_idx];
        plus1    = s1_phase_reg + 2'd1;
        minus1   = s1_phase_reg + 2'd3;

        if (plus1 == prev)
        begin
            raw = DIR_POS;
        end
        else if (minus1 == prev)
        begin
            raw = DIR_NEG;
        end
        else
        begin
            raw = DIR_NONE;
        end

        // hold the history when the step repeats all three, else shift it in
        hist = hist_reg[enc_idx];
        if (raw == hist.h0 && raw == hist.h1 && raw == hist.h2)
        begin
            hist_next = hist;
        end
        else
        begin
            hist_next = '{h2: hist.h1, h1: hist.h0, h0: raw};
        end
        dir = (raw == hist.h0 && hist.h0 == hist.h1) ? raw : DIR_NONE;

        head      = head_reg[enc_idx];
        head_next = (head == HEAD_W'(TIME_SAMPLES - 1)) ? '0 : head + HEAD_W'(1);
        back      = (head >= HEAD_W'(2)) ? head - HEAD_W'(2)
                                         : head + HEAD_W'(TIME_SAMPLES - 2);

        is_step    = s1_valid_reg && in_range && (raw != DIR_NONE);
        step_valid = is_step && (dir != DIR_NONE);
        s1_done    = s1_valid_reg && (step_ready || !step_valid);

        ram.we    = is_step && s1_done;
        ram.waddr = slot_addr(enc_idx, head);
        ram.wdata = s1_now_reg;
        ram.re    = step_valid && s1_done;
        ram.raddr = slot_addr(enc_idx, back);

        step.enc        = s1_enc_reg;
        step.dir        = dir;
        step.now        = s1_now_reg;
        step.back_valid = ring_valid_reg[ram.raddr];
    end

    assign samples.ready = !s1_valid_reg || s1_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            ring_valid_reg <= '0;
            for (int i = 0; i < ENCODER_COUNT; i++)
            begin
                phase_reg[i] <= '0;
                hist_reg[i]  <= '0;
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            if (samples.ready)
            begin
                s1_valid_reg <= samples.valid;
            end
            if (s1_done && in_range)
            begin
                phase_reg[enc_idx] <= s1_phase_reg;
            end
            if (is_step && s1_done)
            begin
                hist_reg[enc_idx]         <= hist_next;
                head_reg[enc_idx]         <= head_next;
                ring_valid_reg[ram.waddr] <= 1'b1;
            end
        end
    end

    // phase code: A only is 3, both is 2, B only is 1
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_enc_reg   <= samples.encoder_index;
            s1_phase_reg <= {samples.phase_a, samples.phase_a ^ samples.phase_b};
            s1_now_reg   <= samples.now_ms;
        end
    end

    a_read_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram.re |-> ram.we)
        else $error("step-time read without the matching write");

    a_read_other_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram.re |-> ram.raddr != ram.waddr)
        else $error("step-time read and write hit the same slot");

    a_step_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid |-> s1_valid_reg)
        else $error("step offered with no sample in the input register");

endmodule

FILE: sv/qed_speed.sv
// Speed stage: limit registers, interval classing and the event output register.
`timescale 1ns / 1ps

module qed_speed import qed_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    qed_cfg_if.sink      cfg,
    input  logic         step_valid,
    input  step_t        step,
    output logic         step_ready,
    input  time_t        rdata,
    qed_event_if.source  events
);

    limit_t fastest_limit_reg;
    limit_t fast_limit_reg;
    limit_t medium_limit_reg;
    limit_t slow_limit_reg;

    logic   s2_valid_reg;
    step_t  s2_reg;
    logic   out_valid_reg;
    enc_t   out_enc_reg;
    dir_t   out_dir_reg;
    level_t out_level_reg;

    logic   out_free;
    time_t  back_time;
    time_t  delta;
    level_t level;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fastest_limit_reg <= FASTEST_LIMIT_RESET;
            fast_limit_reg    <= FAST_LIMIT_RESET;
            medium_limit_reg  <= MEDIUM_LIMIT_RESET;
            slow_limit_reg    <= SLOW_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FASTEST_LIMIT: fastest_limit_reg <= cfg.data;
                CFG_FAST_LIMIT:    fast_limit_reg    <= cfg.data;
                CFG_MEDIUM_LIMIT:  medium_limit_reg  <= cfg.data;
                CFG_SLOW_LIMIT:    slow_limit_reg    <= cfg.data;
                default:           ;
            endcase
        end
    end

    assign out_free   = !out_valid_reg || events.ready;
    assign step_ready = !s2_valid_reg || out_free;

    // a slot never written reads as time zero
    always_comb
    begin
        back_time = s2_reg.back_valid ? rdata : '0;
        delta     = s2_reg.now - back_time;
        if (delta < TIME_W'(fastest_limit_reg))
        begin
            level = LEVEL_FASTEST;
        end
        else if (delta < TIME_W'(fast_limit_reg))
        begin
            level = LEVEL_FAST;
        end
        else if (delta < TIME_W'(medium_limit_reg))
        begin
            level = LEVEL_MEDIUM;
        end
        else if (delta < TIME_W'(slow_limit_reg))
        begin
            level = LEVEL_SLOW;
        end
        else
        begin
            level = LEVEL_STILL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_ready)
            begin
                s2_valid_reg <= step_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_valid && step_ready)
        begin
            s2_reg <= step;
        end
        if (s2_valid_reg && out_free)
        begin
            out_enc_reg   <= s2_reg.enc;
            out_dir_reg   <= s2_reg.dir;
            out_level_reg <= level;
        end
    end

    assign events.valid         = out_valid_reg;
    assign events.which_encoder = out_enc_reg;
    assign events.direction     = out_dir_reg;
    assign events.speed_level   = out_level_reg;

    a_dir_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_dir_reg == DIR_POS || out_dir_reg == DIR_NEG))
        else $error("event word with no direction");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_level_reg <= LEVEL_FASTEST)
        else $error("speed level out of range");

    a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_free |=> $stable(rdata) && $stable(s2_reg))
        else $error("held step or its ring read changed while stalled");

endmodule

FILE: sv/quadrature_encoder_direction_speed.sv
// Top level of the quadrature encoder direction and speed decoder.
// Accepts one A/B sample per cycle for any of 16 encoders while the output is not stalled,
// and emits an event word (encoder, filtered direction, speed level 0..4) through the
// input, speed stage and event output registers when the encoder made a step and its last
// three steps agree. The rate is set by the per-encoder read-modify-write of phase, step
// history and ring head in the tracking stage and by the registered read of the step-time
// RAM (16 encoders x 8 stamps x 32 bits) that feeds the speed stage. The tracking stage
// keeps one valid bit per RAM entry, cleared at reset, so no clearing pass is needed after
// reset. Limit registers take writes at any time and are meant to change only while idle.
`timescale 1ns / 1ps

module quadrature_encoder_direction_speed import qed_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    qed_sample_if.sink   samples,
    qed_event_if.source  events,
    qed_cfg_if.sink      cfg
);

    logic     step_valid;
    logic     step_ready;
    step_t    step;
    ram_req_t ram;
    time_t    rdata;

    qed_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .step_ready (step_ready),
        .step_valid (step_valid),
        .step       (step),
        .ram        (ram)
    );

    qed_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RAM_DEPTH)
    ) u_times (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

    qed_speed u_speed (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step_valid (step_valid),
        .step       (step),
        .step_ready (step_ready),
        .rdata      (rdata),
        .events     (events)
    );

endmodule
